[sv/iqtr_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the quarter-turn image rotator
package iqtr_pkg;

   localparam int DIM_W      = 9;
   localparam int CNT_W      = 18;
   localparam int PIX_W      = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int TURN_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_QUARTERS  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCKWISE = CSR_IDX_W'(3);

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_FETCH   = 2'd1,
      REQ_RESTART = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   typedef enum logic [TURN_W-1:0] {
      TURN_NONE = 2'd0,
      TURN_ONE  = 2'd1,
      TURN_TWO  = 2'd2,
      TURN_BACK = 2'd3
   } turn_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic [CNT_W-1:0] n;
      turn_type         turns;
      logic [DIM_W-1:0] oc;
   } geom_type;

   typedef struct packed {
      logic take;
      logic store;
      logic clear;
      logic div_start;
      logic addr_calc;
      logic mem_rd;
      logic rsp_load;
      logic rsp_err;
      logic rsp_fetch;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         load_ok;
      logic         fetch_ok;
      logic         dirty;
      logic         div_busy;
      logic         rsp_free;
   } stat_type;

endpackage

[sv/iqtr_csr.sv]
`timescale 1ns / 1ps
// configuration registers and derived frame geometry
module iqtr_csr
   import iqtr_pkg::*;
#(
   parameter int MAX_DIM = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output geom_type              geom,
   output logic                  geom_chg
);

   logic [DIM_W-1:0]  rows_ff, rows_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic [TURN_W-1:0] qt_ff, qt_in;
   logic              cw_ff, cw_in;
   geom_type          geom_ff, geom_in;
   logic [DIM_W-1:0]  rc, cc;
   logic              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;
   assign geom_chg  = wr && (csr_index == CSR_ROWS || csr_index == CSR_COLS ||
                             csr_index == CSR_QUARTERS || csr_index == CSR_CLOCKWISE);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      qt_in   = qt_ff;
      cw_in   = cw_ff;
      if (wr) begin
         case (csr_index)
            CSR_ROWS:      rows_in = csr_data;
            CSR_COLS:      cols_in = csr_data;
            CSR_QUARTERS:  qt_in   = csr_data[TURN_W-1:0];
            CSR_CLOCKWISE: cw_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         rc = DIM_W'(1);
      end else if (32'(rows_ff) > MAX_DIM) begin
         rc = DIM_W'(MAX_DIM);
      end else begin
         rc = rows_ff;
      end
      if (cols_ff == '0) begin
         cc = DIM_W'(1);
      end else if (32'(cols_ff) > MAX_DIM) begin
         cc = DIM_W'(MAX_DIM);
      end else begin
         cc = cols_ff;
      end
      geom_in.rows  = rc;
      geom_in.cols  = cc;
      geom_in.n     = CNT_W'(CNT_W'(rc) * CNT_W'(cc));
      geom_in.turns = cw_ff ? turn_type'(qt_ff) : turn_type'(TURN_W'(-qt_ff));
      geom_in.oc    = geom_in.turns[0] ? rc : cc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(1);
         cols_ff <= DIM_W'(1);
         qt_ff   <= '0;
         cw_ff   <= 1'b1;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         qt_ff   <= qt_in;
         cw_ff   <= cw_in;
      end
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

[sv/iqtr_ctrl.sv]
`timescale 1ns / 1ps
// transaction sequencer of the rotator
module iqtr_ctrl
   import iqtr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_ADDR,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      err_ff, err_in;
   logic      fetch_ff, fetch_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      fetch_in = fetch_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            err_in   = 1'b0;
            fetch_in = 1'b0;
            state_in = S_RESP;
            case (stat.kind)
               REQ_LOAD: begin
                  cmd.store = stat.load_ok;
                  err_in    = !stat.load_ok;
               end
               REQ_FETCH: begin
                  if (!stat.fetch_ok) begin
                     err_in = 1'b1;
                  end else if (stat.dirty) begin
                     cmd.div_start = 1'b1;
                     fetch_in      = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     fetch_in = 1'b1;
                     state_in = S_ADDR;
                  end
               end
               REQ_RESTART: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.rsp_err   = err_ff;
      cmd.rsp_fetch = fetch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff   <= 1'b0;
         fetch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         fetch_ff <= fetch_in;
      end
   end

endmodule

[sv/iqtr_dp.sv]
`timescale 1ns / 1ps
// counters, position divider, address unit, frame store and output register
module iqtr_dp
   import iqtr_pkg::*;
#(
   parameter int FRAME_PIXELS = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [PIX_W-1:0] req_tdata,
   input  logic [1:0]       req_tuser,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  geom_type         geom,
   input  logic             geom_chg,
   input  cmd_type          cmd,
   output stat_type         stat
);

   localparam int MEM_AW   = $clog2(FRAME_PIXELS);
   localparam int WIDE_W   = (MEM_AW > CNT_W) ? MEM_AW : CNT_W;
   localparam int DIVC_W   = $clog2(CNT_W + 1);

   logic [PIX_W-1:0]  mem [FRAME_PIXELS];

   req_kind_type      kind_ff;
   logic [PIX_W-1:0]  pix_ff;
   logic [CNT_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]  fetch_cnt_ff, fetch_cnt_in;
   logic [DIM_W-1:0]  r_ff, r_in;
   logic [DIM_W-1:0]  c_ff, c_in;
   logic              dirty_ff, dirty_in;
   logic [DIVC_W-1:0] div_cnt_ff, div_cnt_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  addr_ff;
   logic              oob_ff;
   logic              last_ff;
   logic [PIX_W-1:0]  rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;

   logic              div_busy;
   logic [DIM_W:0]    rem_sh;
   logic              div_ge;
   logic [DIM_W-1:0]  div_rem_nx;
   logic [DIM_W-1:0]  sy, sx;
   logic [CNT_W-1:0]  addr_calc;
   logic              last_calc;
   logic [WIDE_W-1:0] wr_wide, rd_wide;

   // position divider: fetch count over output width, one quotient bit a cycle
   assign div_busy   = (div_cnt_ff != '0);
   assign rem_sh     = {rem_ff, quo_ff[CNT_W-1]};
   assign div_ge     = (rem_sh >= {1'b0, geom.oc});
   assign div_rem_nx = div_ge ? DIM_W'(rem_sh - {1'b0, geom.oc}) : rem_sh[DIM_W-1:0];

   // source position for output position (r, c)
   always_comb begin
      case (geom.turns)
         TURN_NONE: begin
            sy = r_ff;
            sx = c_ff;
         end
         TURN_ONE: begin
            sy = geom.rows - DIM_W'(1) - c_ff;
            sx = r_ff;
         end
         TURN_TWO: begin
            sy = geom.rows - DIM_W'(1) - r_ff;
            sx = geom.cols - DIM_W'(1) - c_ff;
         end
         default: begin
            sy = c_ff;
            sx = geom.cols - DIM_W'(1) - r_ff;
         end
      endcase
   end

   assign addr_calc = CNT_W'(CNT_W'(sy) * CNT_W'(geom.cols)) + CNT_W'(sx);
   assign last_calc = (CNT_W'(fetch_cnt_ff + CNT_W'(1)) == geom.n);
   assign wr_wide   = WIDE_W'(load_cnt_ff);
   assign rd_wide   = WIDE_W'(addr_ff);

   always_comb begin
      stat.kind     = kind_ff;
      stat.load_ok  = (load_cnt_ff < geom.n) && (32'(load_cnt_ff) < FRAME_PIXELS);
      stat.fetch_ok = (load_cnt_ff >= geom.n) && (fetch_cnt_ff < geom.n);
      stat.dirty    = dirty_ff;
      stat.div_busy = div_busy;
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      load_cnt_in  = load_cnt_ff;
      fetch_cnt_in = fetch_cnt_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      dirty_in     = dirty_ff || geom_chg;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      if (cmd.store) begin
         load_cnt_in = load_cnt_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         load_cnt_in  = '0;
         fetch_cnt_in = '0;
         r_in         = '0;
         c_in         = '0;
         dirty_in     = geom_chg;
      end
      if (cmd.div_start) begin
         div_cnt_in = DIVC_W'(CNT_W);
         rem_in     = '0;
         quo_in     = fetch_cnt_ff;
      end else if (div_busy) begin
         div_cnt_in = div_cnt_ff - DIVC_W'(1);
         rem_in     = div_rem_nx;
         quo_in     = {quo_ff[CNT_W-2:0], div_ge};
         if (div_cnt_ff == DIVC_W'(1)) begin
            r_in     = quo_in[DIM_W-1:0];
            c_in     = div_rem_nx;
            dirty_in = geom_chg;
         end
      end
      if (cmd.addr_calc) begin
         fetch_cnt_in = fetch_cnt_ff + CNT_W'(1);
         if ({1'b0, c_ff} + (DIM_W+1)'(1) == {1'b0, geom.oc}) begin
            c_in = '0;
            r_in = r_ff + DIM_W'(1);
         end else begin
            c_in = c_ff + DIM_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         fetch_cnt_ff <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         dirty_ff     <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_cnt_ff  <= load_cnt_in;
         fetch_cnt_ff <= fetch_cnt_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         dirty_ff     <= dirty_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.take) begin
         kind_ff <= req_kind_type'(req_tuser);
         pix_ff  <= req_tdata;
      end
      if (cmd.addr_calc) begin
         addr_ff <= addr_calc;
         oob_ff  <= (32'(addr_calc) >= FRAME_PIXELS);
         last_ff <= last_calc;
      end
      if (cmd.rsp_load) begin
         rsp_pix_ff  <= (cmd.rsp_fetch && !oob_ff) ? rd_ff : '0;
         rsp_last_ff <= cmd.rsp_fetch && last_ff;
         rsp_err_ff  <= cmd.rsp_err;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[wr_wide[MEM_AW-1:0]] <= pix_ff;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[rd_wide[MEM_AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

[sv/image_quarter_turn_rotator_unit.sv]
`timescale 1ns / 1ps
// top level of the quarter-turn image rotator
//
// req channel: one transaction per request; tuser is the request kind
// (load, fetch, restart), tdata the source pixel for loads.
// rsp channel: exactly one transaction per request; tdata is the rotated
// pixel (zero unless a fetch succeeds), tlast marks the final pixel of the
// rotated frame, tuser is the error flag.
// csr channel: register writes (rows, cols, quarter turns, direction),
// always ready; write only while no request is in flight.
// steps: a load, restart or refused request is checked and then answered;
// a fetch also computes the source address and reads the frame store; the
// first fetch after a change of geometry first runs the bit-serial position
// divider.
// one request is in flight at a time; the next is taken once the previous
// response sits in the output register, so a stalled rsp side holds one
// finished response and blocks the following one in its last step.
// reset clears the counters, the output register and the registers to
// rows 1, cols 1, no turn, clockwise; the frame store keeps no reset value.
module image_quarter_turn_rotator_unit
   import iqtr_pkg::*;
#(
   parameter int MAX_DIM      = 256,
   parameter int FRAME_PIXELS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // pixel
   input  logic [1:0]            req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // pixel_out
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,   // error
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   geom_type geom;
   logic     geom_chg;
   cmd_type  cmd;
   stat_type stat;

   iqtr_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .geom_chg  (geom_chg)
   );

   iqtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   iqtr_dp #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .geom       (geom),
      .geom_chg   (geom_chg),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
